// ===== hdl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// shared constants, codes and types of the round-robin task scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int MAX_SLOTS = 8;
   localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int MASK_N    = (MAX_SLOTS < 8) ? MAX_SLOTS : 8;

   // event codes
   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_CREATE = 3'd1;
   localparam logic [2:0] MODE_EXIT   = 3'd2;
   localparam logic [2:0] MODE_BLOCK  = 3'd3;
   localparam logic [2:0] MODE_WAKE   = 3'd4;

   // slot states
   localparam logic [1:0] SLOT_READY   = 2'd0;
   localparam logic [1:0] SLOT_BLOCKED = 2'd1;
   localparam logic [1:0] SLOT_DONE    = 2'd2;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] wake_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  running_task;
      logic        switched;
      logic        halted;
      logic [2:0]  created_index;
      logic        create_refused;
      logic [3:0]  slots_used;
      logic [31:0] switches_total;
      logic [7:0]  done_mask;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic scan;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic yield;
      logic found;
      logic last;
   } stat_type;

endpackage

// ===== hdl/rrts_dpath.sv =====
// ----------------------------------------------------------------------------
// rrts_dpath
// slot table, scheduler state, round-robin scan step and result register
// ----------------------------------------------------------------------------
module rrts_dpath (
   input  logic              clock,
   input  logic              reset,
   input  rrts_pkg::req_type req_data,
   input  rrts_pkg::cmd_type cmd,
   output rrts_pkg::stat_type stat,
   output rrts_pkg::rsp_type rsp_data
);
   import rrts_pkg::*;

   req_type           item_ff;
   logic [1:0]        slot_ff [MAX_SLOTS];
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [SLOT_W-1:0] run_ff, run_in;
   logic [SLOT_W-1:0] cand_ff, cand_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic [31:0]       swcnt_ff, swcnt_in;
   logic              halt_ff, halt_in;
   logic              sw_ff, sw_in;
   logic              refused_ff, refused_in;
   logic [2:0]        created_ff, created_in;
   rsp_type           rsp_ff, rsp_in;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [1:0]        wr_data;
   logic [7:0]        mask;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] x,
                                                    input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] nx;
      nx = CNT_W'(x) + CNT_W'(1);
      return (nx >= n) ? '0 : SLOT_W'(nx);
   endfunction

   assign stat.yield = !halt_ff &&
                       (item_ff.mode == MODE_TICK || item_ff.mode == MODE_EXIT);
   assign stat.found = (slot_ff[cand_ff] == SLOT_READY);
   assign stat.last  = (step_ff == used_ff);

   always_comb begin
      used_in    = used_ff;
      run_in     = run_ff;
      cand_in    = cand_ff;
      step_in    = step_ff;
      swcnt_in   = swcnt_ff;
      halt_in    = halt_ff;
      sw_in      = sw_ff;
      refused_in = refused_ff;
      created_in = created_ff;
      wr_en      = 1'b0;
      wr_addr    = run_ff;
      wr_data    = SLOT_READY;
      if (cmd.exec) begin
         sw_in      = 1'b0;
         refused_in = 1'b0;
         created_in = 3'd0;
         cand_in    = next_slot(run_ff, used_ff);
         step_in    = CNT_W'(1);
         if (!halt_ff) begin
            unique case (item_ff.mode)
               MODE_CREATE: begin
                  if (used_ff >= CNT_W'(MAX_SLOTS)) begin
                     refused_in = 1'b1;
                  end else begin
                     created_in = 3'(used_ff);
                     wr_en      = 1'b1;
                     wr_addr    = SLOT_W'(used_ff);
                     wr_data    = SLOT_READY;
                     used_in    = used_ff + CNT_W'(1);
                  end
               end
               MODE_EXIT: begin
                  wr_en   = 1'b1;
                  wr_addr = run_ff;
                  wr_data = SLOT_DONE;
               end
               MODE_BLOCK: begin
                  wr_en   = 1'b1;
                  wr_addr = run_ff;
                  wr_data = SLOT_BLOCKED;
               end
               MODE_WAKE: begin
                  if (int'(item_ff.wake_index) < int'(used_ff) &&
                      int'(item_ff.wake_index) < MAX_SLOTS) begin
                     wr_en   = 1'b1;
                     wr_addr = SLOT_W'(item_ff.wake_index);
                     wr_data = SLOT_READY;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      if (cmd.scan) begin
         if (stat.found) begin
            if (cand_ff != run_ff) begin
               run_in   = cand_ff;
               swcnt_in = swcnt_ff + 32'd1;
               sw_in    = 1'b1;
            end
         end else if (stat.last) begin
            halt_in = 1'b1;
         end else begin
            cand_in = next_slot(cand_ff, used_ff);
            step_in = step_ff + CNT_W'(1);
         end
      end
   end

   // only created slots count toward the done mask
   always_comb begin
      mask = '0;
      for (int s = 0; s < MASK_N; s++) begin
         if (s < int'(used_ff) && slot_ff[s] == SLOT_DONE) begin
            mask[s] = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in.running_task   = 3'(run_ff);
      rsp_in.switched       = sw_ff;
      rsp_in.halted         = halt_ff;
      rsp_in.created_index  = created_ff;
      rsp_in.create_refused = refused_ff;
      rsp_in.slots_used     = 4'(used_ff);
      rsp_in.switches_total = swcnt_ff;
      rsp_in.done_mask      = mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= CNT_W'(1);
         run_ff   <= '0;
         swcnt_ff <= '0;
         halt_ff  <= 1'b0;
      end else begin
         used_ff  <= used_in;
         run_ff   <= run_in;
         swcnt_ff <= swcnt_in;
         halt_ff  <= halt_in;
      end
   end

   // slot 0 starts ready, the rest are written at create
   always_ff @(posedge clock) begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
         if (s == 0 && reset) begin
            slot_ff[s] <= SLOT_READY;
         end else if (wr_en && wr_addr == SLOT_W'(s)) begin
            slot_ff[s] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_data;
      end
      cand_ff    <= cand_in;
      step_ff    <= step_in;
      sw_ff      <= sw_in;
      refused_ff <= refused_in;
      created_ff <= created_in;
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared");
   a_run_in_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(run_ff) < used_ff)
      else $error("running slot beyond used count");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (step_ff != '0 && step_ff <= used_ff))
      else $error("scan step out of range");
`endif

endmodule

// ===== hdl/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrts_ctrl
// sequencer: accept, execute, scan one slot a cycle, hand off the result
// ----------------------------------------------------------------------------
module rrts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  rrts_pkg::stat_type stat,
   output rrts_pkg::cmd_type  cmd
);
   import rrts_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.yield ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.found || stat.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (cmd.exec && $past(cmd.accept)))
      else $error("accepted item not executed");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && stat.last) |=> !cmd.scan)
      else $error("scan ran past last slot");
`endif

endmodule

// ===== hdl/round_robin_task_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_core
// round-robin scheduler over a table of task slots, one result per event
// ----------------------------------------------------------------------------
// req channel: req_valid/req_stall with req_data (mode, wake_index); one item
//   per scheduler event
// rsp channel: rsp_valid/rsp_stall with rsp_data; exactly one item per event,
//   in event order, reporting the state after that event
// path: create, block, wake and unknown events go from accept through execute
//   to finish; tick and exit also pass through the round-robin scan, which
//   visits at most the used slot count
// flow: one event in flight; the next item can be accepted in the cycle
//   after its result is loaded, so the scan and receiver stalls set the rate
// reset: slot 0 ready and running, one slot used, switch count 0, not halted
// rsp stall: the result register holds; one more event may be accepted and
//   processed, and it waits for the register before finishing
// once halted, every event returns the frozen status with halted set
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rrts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrts_pkg::rsp_type rsp_data
);
   import rrts_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrts_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== test/round_robin_task_scheduler_core_tb.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_core_tb
// checks every scheduler status item against a predicted task table, under
// random sender bursts, receiver stalls, two long receiver holds and two drains
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core_tb;

   import rrts_pkg::*;

   localparam int         RANDOM_EVENTS  = 1200;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         SETTLE_CYCLES  = 20;
   localparam logic [2:0] MODE_LAST      = 3'd7;

   typedef struct packed {
      logic [MAX_SLOTS-1:0][1:0] slot_state;
      logic [CNT_W-1:0]          used_slots;
      logic [SLOT_W-1:0]         running;
      logic [31:0]               switch_tally;
      logic                      halted;
   } sched_state_type;

   typedef struct packed {
      req_type data;
      logic    drain_first;
   } pending_event_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_event_type pending_events[$];
   pending_event_type next_event;
   rsp_type           expected_status[$];
   rsp_type           want;
   sched_state_type   plan_model;
   sched_state_type   sched_model;

   int events_accepted = 0;
   int results_seen    = 0;
   int mismatches      = 0;
   int gap_left        = 0;
   int burst_left      = 0;
   int stall_mode      = 0;
   int phase_left      = 0;
   int hold_left       = 0;
   int holds_done      = 0;
   int idle_cycles     = 0;

   round_robin_task_scheduler_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic sched_state_type reset_state();
      sched_state_type st;
      st            = '0;
      st.used_slots = CNT_W'(1);
      return st;
   endfunction

   // first ready slot after the running one, running slot last
   function automatic int next_ready(sched_state_type st);
      int cand;
      for (int i = 1; i <= st.used_slots; i++) begin
         cand = (st.running + i) % st.used_slots;
         if (st.slot_state[cand] == SLOT_READY) return cand;
      end
      return -1;
   endfunction

   function automatic rsp_type schedule_event(inout sched_state_type st, input req_type ev);
      rsp_type r;
      int      nxt;
      r = '0;
      if (!st.halted) begin
         case (ev.mode)
            MODE_TICK, MODE_EXIT: begin
               if (ev.mode == MODE_EXIT) st.slot_state[st.running] = SLOT_DONE;
               nxt = next_ready(st);
               if (nxt < 0) begin
                  st.halted = 1'b1;
               end else if (nxt != st.running) begin
                  st.running      = SLOT_W'(nxt);
                  st.switch_tally = st.switch_tally + 32'd1;
                  r.switched      = 1'b1;
               end
            end
            MODE_CREATE: begin
               if (st.used_slots >= MAX_SLOTS) begin
                  r.create_refused = 1'b1;
               end else begin
                  r.created_index                = 3'(st.used_slots);
                  st.slot_state[st.used_slots]   = SLOT_READY;
                  st.used_slots                  = st.used_slots + CNT_W'(1);
               end
            end
            MODE_BLOCK: begin
               st.slot_state[st.running] = SLOT_BLOCKED;
            end
            MODE_WAKE: begin
               if (ev.wake_index < st.used_slots) st.slot_state[ev.wake_index] = SLOT_READY;
            end
            default: begin
            end
         endcase
      end
      for (int s = 0; s < MASK_N; s++) begin
         if (s < st.used_slots && st.slot_state[s] == SLOT_DONE) r.done_mask[s] = 1'b1;
      end
      r.running_task   = 3'(st.running);
      r.halted         = st.halted;
      r.slots_used     = 4'(st.used_slots);
      r.switches_total = st.switch_tally;
      return r;
   endfunction

   function automatic req_type make_event(logic [2:0] code, logic [2:0] slot);
      req_type ev;
      ev.mode       = code;
      ev.wake_index = slot;
      return ev;
   endfunction

   function automatic req_type random_event();
      int         pick;
      logic [2:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 30) code = MODE_TICK;
      else if (pick < 38) code = MODE_CREATE;
      else if (pick < 50) code = MODE_EXIT;
      else if (pick < 64) code = MODE_BLOCK;
      else if (pick < 92) code = MODE_WAKE;
      else code = 3'($urandom_range(MODE_WAKE + 1, MODE_LAST));
      return make_event(code, 3'($urandom_range(0, 7)));
   endfunction

   task automatic queue_event(input req_type ev, input logic drain);
      pending_event_type pe;
      rsp_type           ignored;
      pe.data        = ev;
      pe.drain_first = drain;
      ignored        = schedule_event(plan_model, ev);
      pending_events.push_back(pe);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, act_val);
      end
   endtask

   // sender: bursts and gaps, optional drain before an item
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_data    <= '0;
         sched_model = reset_state();
      end else begin
         if (req_valid && !req_stall) begin
            expected_status.push_back(schedule_event(sched_model, req_data));
            events_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_events.size() > 0 &&
                         !(pending_events[0].drain_first && events_accepted != results_seen)) begin
               next_event = pending_events.pop_front();
               req_valid  <= 1'b1;
               req_data   <= next_event.data;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with two long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_done < 2 && results_seen >= (holds_done + 1) * 400) begin
         hold_left = HOLD_CYCLES;
         holds_done++;
         rsp_stall <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(16, 96);
         end else begin
            phase_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // status checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_status.size() == 0) begin
            mismatches++;
            $display("%0t: expected no item, got %0h", $time, rsp_data);
         end else begin
            want = expected_status.pop_front();
            check_field("running_task", 32'(want.running_task),
                        32'(rsp_data.running_task));
            check_field("switched", 32'(want.switched), 32'(rsp_data.switched));
            check_field("halted", 32'(want.halted), 32'(rsp_data.halted));
            check_field("created_index", 32'(want.created_index),
                        32'(rsp_data.created_index));
            check_field("create_refused", 32'(want.create_refused),
                        32'(rsp_data.create_refused));
            check_field("slots_used", 32'(want.slots_used), 32'(rsp_data.slots_used));
            check_field("switches_total", want.switches_total, rsp_data.switches_total);
            check_field("done_mask", 32'(want.done_mask), 32'(rsp_data.done_mask));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_type         ev;
      sched_state_type probe;
      rsp_type         probe_rsp;
      int              others;

      plan_model = reset_state();

      // directed: lone tick, wake past count, unknown modes, full table
      queue_event(make_event(MODE_TICK, 3'd0), 1'b0);
      queue_event(make_event(MODE_WAKE, 3'd7), 1'b0);
      for (int m = MODE_WAKE + 1; m <= MODE_LAST; m++)
         queue_event(make_event(3'(m), 3'($urandom_range(0, 7))), 1'b0);
      repeat (MAX_SLOTS) queue_event(make_event(MODE_CREATE, 3'd0), 1'b0);
      queue_event(make_event(MODE_TICK, 3'd0), 1'b0);
      queue_event(make_event(MODE_BLOCK, 3'd0), 1'b0);
      queue_event(make_event(MODE_TICK, 3'd0), 1'b0);
      queue_event(make_event(MODE_EXIT, 3'd0), 1'b0);
      queue_event(make_event(MODE_WAKE, 3'd1), 1'b0);
      queue_event(make_event(MODE_WAKE, 3'd2), 1'b0);
      queue_event(make_event(MODE_WAKE, 3'd0), 1'b0);
      queue_event(make_event(MODE_TICK, 3'd0), 1'b0);

      // random events, steered away from halting until the end
      for (int n = 0; n < RANDOM_EVENTS; n++) begin
         ev        = random_event();
         probe     = plan_model;
         probe_rsp = schedule_event(probe, ev);
         if (probe_rsp.halted)
            ev = make_event(MODE_WAKE, 3'($urandom_range(0, plan_model.used_slots - 1)));
         queue_event(ev, n == 0 || n == RANDOM_EVENTS / 2);
      end

      // run every task down until the scheduler halts, then poke it
      while (!plan_model.halted) begin
         others = 0;
         for (int s = 0; s < plan_model.used_slots; s++) begin
            if (s != plan_model.running && plan_model.slot_state[s] == SLOT_READY) others++;
         end
         if (others > 0) begin
            queue_event(make_event(MODE_EXIT, 3'($urandom_range(0, 7))), 1'b0);
         end else begin
            queue_event(make_event(MODE_BLOCK, 3'($urandom_range(0, 7))), 1'b0);
            queue_event(make_event(MODE_TICK, 3'($urandom_range(0, 7))), 1'b0);
         end
      end
      for (int m = MODE_TICK; m <= MODE_LAST; m++)
         queue_event(make_event(3'(m), 3'($urandom_range(0, 7))), 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_events.size() > 0 || req_valid || events_accepted != results_seen);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (expected_status.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected items never arrived", $time, expected_status.size());
      end
      $display("%0d scheduler events checked, %0d task switches predicted,", results_seen,
               sched_model.switch_tally);
      $display("full table, blocked and done slots, wakes and the halted freeze covered");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
